// File: rtl/core/ifd_pkg.sv
// Package for the info frame deframer: framing constants, FSM and result types.
// No dependencies; used by ifd_parser, ifd_out_queue and info_frame_deframer.
package ifd_pkg;

  // Payload limit and counter widths
  localparam int unsigned MAX_PAYLOAD = 1024;
  localparam int unsigned CNT_W       = $clog2(MAX_PAYLOAD + 1);
  localparam int unsigned FLEN_W      = 11;

  // Output queue geometry (two results per beat at most)
  localparam int unsigned OQ_DEPTH = 4;
  localparam int unsigned OQ_AW    = $clog2(OQ_DEPTH);

  // Line codes
  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [7:0] ESC_BYTE  = 8'h7D;
  localparam logic [7:0] CTRL_I0   = 8'h00;
  localparam logic [7:0] CTRL_I1   = 8'h40;
  localparam logic [7:0] CTRL_DISC = 8'h0B;
  localparam logic [6:0] REPLY_RR  = 7'h05;
  localparam logic [6:0] REPLY_REJ = 7'h01;

  localparam logic [7:0] ADDR_RESET = 8'h03;

  typedef enum logic [2:0] {
    ST_HUNT,
    ST_FLAG,
    ST_ADDR,
    ST_CTRL,
    ST_DATA,
    ST_ESC
  } state_e;

  typedef enum logic [1:0] {
    KIND_DATA,
    KIND_GOOD,
    KIND_BAD,
    KIND_DISC
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [7:0]        data;
    logic [7:0]        reply;
    logic [FLEN_W-1:0] flen;
    logic              last;
  } result_t;

endpackage

// File: rtl/core/ifd_parser.sv
// Frame parser: header check, byte destuffing, BCC2 check, result generation.
// Depends on ifd_pkg. Produces up to two results per processed byte.
module ifd_parser (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            fire_i,
  input  logic [7:0]      byte_i,
  input  logic [7:0]      addr_i,
  output ifd_pkg::result_t res0_o,
  output ifd_pkg::result_t res1_o,
  output logic [1:0]      n_o
);
  import ifd_pkg::*;

  // Payload tracking: held-back byte, running XOR, count, overflow
  typedef struct packed {
    logic [7:0]       held;
    logic             hv;
    logic [7:0]       xs;
    logic [CNT_W-1:0] cnt;
    logic             ov;
  } pay_t;

  // Release the held byte (if any, unless the payload is full) and hold the new one
  function automatic pay_t push_f(input pay_t p, input logic [7:0] b, output logic emit);
    pay_t r;
    r    = p;
    emit = 1'b0;
    if (p.hv) begin
      if (p.cnt >= CNT_W'(MAX_PAYLOAD)) begin
        r.ov = 1'b1;
      end else begin
        emit  = 1'b1;
        r.xs  = p.xs ^ p.held;
        r.cnt = p.cnt + CNT_W'(1);
      end
    end
    r.held = b;
    r.hv   = 1'b1;
    return r;
  endfunction

  state_e     state_q, state_d;
  pay_t       pay_q, pay_d, pay_mid;
  logic       seq_q, seq_d;
  logic       ctrl_q, ctrl_d;
  logic       e1, e2, good;
  result_t    res0, res1;
  logic [1:0] n;

  // State registers, advanced once per processed beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_HUNT;
      pay_q   <= '0;
      seq_q   <= 1'b1;
      ctrl_q  <= 1'b0;
    end else if (fire_i) begin
      state_q <= state_d;
      pay_q   <= pay_d;
      seq_q   <= seq_d;
      ctrl_q  <= ctrl_d;
    end
  end

  // Next state and results
  always_comb begin
    state_d = state_q;
    pay_d   = pay_q;
    pay_mid = pay_q;
    seq_d   = seq_q;
    ctrl_d  = ctrl_q;
    e1      = 1'b0;
    e2      = 1'b0;
    good    = 1'b0;
    res0    = '0;
    res1    = '0;
    n       = 2'd0;
    unique case (state_q)
      ST_FLAG: begin
        if (byte_i == addr_i) begin
          state_d = ST_ADDR;
        end else if (byte_i != FLAG_BYTE) begin
          state_d = ST_HUNT;
        end
      end
      ST_ADDR: begin
        if (byte_i == CTRL_I0 || byte_i == CTRL_I1) begin
          ctrl_d  = (byte_i == CTRL_I1);
          state_d = ST_CTRL;
        end else if (byte_i == FLAG_BYTE) begin
          state_d = ST_FLAG;
        end else if (byte_i == CTRL_DISC) begin
          res0.kind = KIND_DISC;
          res0.last = 1'b1;
          n         = 2'd1;
          state_d   = ST_HUNT;
        end else begin
          state_d = ST_HUNT;
        end
      end
      ST_CTRL: begin
        if (byte_i == (addr_i ^ (ctrl_q ? CTRL_I1 : CTRL_I0))) begin
          state_d = ST_DATA;
          pay_d   = '0;
        end else if (byte_i == FLAG_BYTE) begin
          state_d = ST_FLAG;
        end else begin
          state_d = ST_HUNT;
        end
      end
      ST_DATA: begin
        if (byte_i == ESC_BYTE) begin
          state_d = ST_ESC;
        end else if (byte_i == FLAG_BYTE) begin
          // Closing flag: held byte is BCC2
          good       = pay_q.hv && !pay_q.ov && (pay_q.held == pay_q.xs);
          res0.kind  = good ? KIND_GOOD : KIND_BAD;
          res0.reply = {seq_q, good ? REPLY_RR : REPLY_REJ};
          res0.flen  = FLEN_W'(pay_q.cnt);
          res0.last  = 1'b1;
          n          = 2'd1;
          if (good) begin
            seq_d = ~seq_q;
          end
          state_d = ST_HUNT;
        end else begin
          pay_d = push_f(pay_q, byte_i, e1);
          if (e1) begin
            res0.kind = KIND_DATA;
            res0.data = pay_q.held;
            res0.last = 1'b1;
            n         = 2'd1;
          end
        end
      end
      ST_ESC: begin
        state_d = ST_DATA;
        // Escape before an ordinary byte keeps the escape itself
        if (byte_i != ESC_BYTE && byte_i != FLAG_BYTE) begin
          pay_mid = push_f(pay_q, ESC_BYTE, e1);
        end
        pay_d = push_f(pay_mid, byte_i, e2);
        if (e1) begin
          res0.kind = KIND_DATA;
          res0.data = pay_q.held;
          if (e2) begin
            res1.kind = KIND_DATA;
            res1.data = pay_mid.held;
            res1.last = 1'b1;
            n         = 2'd2;
          end else begin
            res0.last = 1'b1;
            n         = 2'd1;
          end
        end else if (e2) begin
          res0.kind = KIND_DATA;
          res0.data = pay_mid.held;
          res0.last = 1'b1;
          n         = 2'd1;
        end
      end
      default: begin
        state_d = (byte_i == FLAG_BYTE) ? ST_FLAG : ST_HUNT;
      end
    endcase
  end

  assign res0_o = res0;
  assign res1_o = res1;
  assign n_o    = n;

endmodule

// File: rtl/core/ifd_out_queue.sv
// Result queue: takes zero, one or two results per cycle, delivers one per beat.
// Depends on ifd_pkg.
module ifd_out_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [1:0]       push_n_i,
  input  ifd_pkg::result_t res0_i,
  input  ifd_pkg::result_t res1_i,
  output logic             room_o,
  output logic             valid_o,
  input  logic             ready_i,
  output ifd_pkg::result_t res_o
);
  import ifd_pkg::*;

  result_t          mem_q [OQ_DEPTH];
  logic [OQ_AW-1:0] wp_q, rp_q;
  logic [OQ_AW:0]   cnt_q;
  logic             pop;

  assign pop     = (cnt_q != '0) && ready_i;
  assign valid_o = (cnt_q != '0);
  assign res_o   = mem_q[rp_q];
  // Space for a worst-case beat without looking at the consumer
  assign room_o  = (cnt_q <= (OQ_AW+1)'(OQ_DEPTH - 2));

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      mem_q[wp_q] <= res0_i;
    end
    if (push_n_i == 2'd2) begin
      mem_q[wp_q + OQ_AW'(1)] <= res1_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_q + OQ_AW'(push_n_i);
      rp_q  <= rp_q + OQ_AW'(pop);
      cnt_q <= cnt_q + (OQ_AW+1)'(push_n_i) - (OQ_AW+1)'(pop);
    end
  end

endmodule

// File: rtl/core/info_frame_deframer.sv
// Info frame deframer top: input register, frame parser, result queue.
// Throughput: one byte per cycle while the result queue has room; a byte that
// yields two results (escape before an ordinary byte) takes two output beats, so the
// result queue sets the sustained rate.
// Reset (rst_ni low, asynchronous): hunting for a flag, sequence bit 1, address 0x03.
module info_frame_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,       // address_byte
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,    // [7:0] rx_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,    // [7:0] data_byte, [15:8] reply_control,
                                         // [26:16] frame_length, [31:27] zero
  output logic [1:0]  m_axis_tuser_o,    // [1:0] kind
  output logic        m_axis_tlast_o
);
  import ifd_pkg::*;

  logic [7:0] addr_val_q;
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       fire, room, s_acc;
  result_t    res0, res1, res_out;
  logic [1:0] push_n;

  // Address register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_val_q <= ADDR_RESET;
    end else if (cfg_we_i) begin
      addr_val_q <= cfg_wdata_i;
    end
  end

  // Input register
  assign fire            = in_valid_q && room;
  assign s_axis_tready_o = !in_valid_q || fire;
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_acc) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      in_byte_q <= s_axis_tdata_i;
    end
  end

  ifd_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .byte_i (in_byte_q),
    .addr_i (addr_val_q),
    .res0_o (res0),
    .res1_o (res1),
    .n_o    (push_n)
  );

  ifd_out_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_n_i (fire ? push_n : 2'd0),
    .res0_i   (res0),
    .res1_i   (res1),
    .room_o   (room),
    .valid_o  (m_axis_tvalid_o),
    .ready_i  (m_axis_tready_i),
    .res_o    (res_out)
  );

  // Output packing
  assign m_axis_tdata_o = {5'b0, res_out.flen, res_out.reply, res_out.data};
  assign m_axis_tuser_o = res_out.kind;
  assign m_axis_tlast_o = res_out.last;

endmodule

// File: tb/info_frame_deframer_tb.sv
// Self-checking testbench for info_frame_deframer: builds line bytes, predicts each result beat.
// Depends on ifd_pkg (line codes, limits, state_e, kind_e, result_t) and the info_frame_deframer RTL only.
module info_frame_deframer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ifd_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int PHASE_BYTES  = 30;
  localparam int HOLD_AFTER   = 600;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE       = 8;
  localparam int N_PHASES     = 6;
  localparam int DIRECTED_LEN = 34;

  // Hand-written opening sequence, address at its reset value
  localparam logic [7:0] DIRECTED [DIRECTED_LEN] = '{
    8'h00, 8'hFF,                                        // noise while hunting
    FLAG_BYTE, FLAG_BYTE, ADDR_RESET, CTRL_DISC,         // repeated flag, disconnect
    FLAG_BYTE, ADDR_RESET, FLAG_BYTE,                    // flag in control position
    ADDR_RESET, CTRL_I1, 8'h43,
    8'hFF, 8'h00, ESC_BYTE, FLAG_BYTE, ESC_BYTE, ESC_BYTE,
    ESC_BYTE, 8'h11, 8'h90, FLAG_BYTE,                   // stuffed payload, good check
    FLAG_BYTE, ADDR_RESET, CTRL_I0, FLAG_BYTE,           // flag in check position
    ADDR_RESET, CTRL_I0, ADDR_RESET, FLAG_BYTE,          // empty frame
    FLAG_BYTE, 8'h05,                                    // wrong address
    FLAG_BYTE, FLAG_BYTE
  };

  logic        clk_i;
  logic        rst_ni   = 1'b0;
  logic        cfg_we   = 1'b0;
  logic [7:0]  cfg_wdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;                 // [7:0] data, [15:8] reply, [26:16] length
  logic [1:0]  m_tuser;                 // [1:0] kind
  logic        m_tlast;

  // Stimulus and expectation stores
  logic [7:0] line_q[$];
  result_t    deframed_q[$];

  int          err_cnt   = 0;
  int          cycle_cnt = 0;
  int          bytes_in  = 0;
  int          idle_pct  = 0;
  int          src_gap   = 0;
  int          sink_gap  = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  int          step_results;

  // Predictor state
  state_e      frm_state = ST_HUNT;
  logic [7:0]  exp_addr  = ADDR_RESET;
  logic [7:0]  hold_byte = '0;
  bit          hold_ok   = 1'b0;
  logic [7:0]  pay_xor   = '0;
  int unsigned pay_cnt   = 0;
  bit          pay_ovf   = 1'b0;
  bit          seq_bit   = 1'b1;
  bit          ctrl_hi   = 1'b0;

  info_frame_deframer u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void emit(kind_e k, logic [7:0] d, logic [7:0] r, logic [FLEN_W-1:0] l);
    result_t res;
    res.kind  = k;
    res.data  = d;
    res.reply = r;
    res.flen  = l;
    res.last  = 1'b0;
    deframed_q.push_back(res);
    step_results++;
  endfunction

  // Release the held byte (unless the payload is full) and hold the new one
  function automatic void push_payload(logic [7:0] b);
    if (hold_ok) begin
      if (pay_cnt >= MAX_PAYLOAD) begin
        pay_ovf = 1'b1;
      end else begin
        emit(KIND_DATA, hold_byte, '0, '0);
        pay_xor ^= hold_byte;
        pay_cnt++;
      end
    end
    hold_byte = b;
    hold_ok   = 1'b1;
  endfunction

  function automatic void deframe_byte(logic [7:0] b);
    step_results = 0;
    case (frm_state)
      ST_FLAG: begin
        if (b == exp_addr) frm_state = ST_ADDR;
        else if (b != FLAG_BYTE) frm_state = ST_HUNT;
      end
      ST_ADDR: begin
        if (b == CTRL_I0 || b == CTRL_I1) begin
          ctrl_hi   = (b == CTRL_I1);
          frm_state = ST_CTRL;
        end else if (b == FLAG_BYTE) begin
          frm_state = ST_FLAG;
        end else if (b == CTRL_DISC) begin
          emit(KIND_DISC, '0, '0, '0);
          frm_state = ST_HUNT;
        end else begin
          frm_state = ST_HUNT;
        end
      end
      ST_CTRL: begin
        if (b == (exp_addr ^ (ctrl_hi ? CTRL_I1 : CTRL_I0))) begin
          frm_state = ST_DATA;
          hold_byte = '0;
          hold_ok   = 1'b0;
          pay_xor   = '0;
          pay_cnt   = 0;
          pay_ovf   = 1'b0;
        end else if (b == FLAG_BYTE) begin
          frm_state = ST_FLAG;
        end else begin
          frm_state = ST_HUNT;
        end
      end
      ST_DATA: begin
        if (b == ESC_BYTE) begin
          frm_state = ST_ESC;
        end else if (b == FLAG_BYTE) begin
          // closing flag: the held byte is the payload check
          if (hold_ok && !pay_ovf && hold_byte == pay_xor) begin
            emit(KIND_GOOD, '0, {seq_bit, REPLY_RR}, FLEN_W'(pay_cnt));
            seq_bit = ~seq_bit;
          end else begin
            emit(KIND_BAD, '0, {seq_bit, REPLY_REJ}, FLEN_W'(pay_cnt));
          end
          frm_state = ST_HUNT;
        end else begin
          push_payload(b);
        end
      end
      ST_ESC: begin
        frm_state = ST_DATA;
        if (b != ESC_BYTE && b != FLAG_BYTE) push_payload(ESC_BYTE);
        push_payload(b);
      end
      default: frm_state = (b == FLAG_BYTE) ? ST_FLAG : ST_HUNT;
    endcase
    if (step_results > 0) deframed_q[deframed_q.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------- stimulus

  // Random line byte, biased toward the flag and escape codes
  function automatic logic [7:0] line_byte();
    case ($urandom_range(0, 9))
      0:       return FLAG_BYTE;
      1:       return ESC_BYTE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic queue_frame(input int n_data, input bit bad_check, input bit use_i1);
    logic [7:0] body[$];
    logic [7:0] sum;
    logic [7:0] ctl;
    sum = '0;
    ctl = use_i1 ? CTRL_I1 : CTRL_I0;
    for (int i = 0; i < n_data; i++) begin
      body.push_back(line_byte());
      sum ^= body[i];
    end
    body.push_back(bad_check ? sum ^ 8'($urandom_range(1, 255)) : sum);
    line_q.push_back(FLAG_BYTE);
    line_q.push_back(exp_addr);
    line_q.push_back(ctl);
    line_q.push_back(exp_addr ^ ctl);
    foreach (body[i]) begin
      if (body[i] == FLAG_BYTE) begin
        line_q.push_back(ESC_BYTE);
        line_q.push_back(FLAG_BYTE);
      end else if (body[i] == ESC_BYTE) begin
        line_q.push_back(ESC_BYTE);
        // a lone escape ahead of an ordinary byte stands for itself
        if (i + 1 >= body.size() || body[i+1] == FLAG_BYTE || body[i+1] == ESC_BYTE ||
            $urandom_range(0, 1) == 0)
          line_q.push_back(ESC_BYTE);
      end else begin
        line_q.push_back(body[i]);
      end
    end
    line_q.push_back(FLAG_BYTE);
  endtask

  // Mostly well-formed frames, with bad checks, disconnects, empty frames, bad headers and noise
  task automatic queue_random_traffic(input int target);
    int pick;
    int n;
    while (line_q.size() < target) begin
      pick = $urandom_range(0, 99);
      n    = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
      if (pick < 55) begin
        queue_frame(n, 1'b0, $urandom_range(0, 1));
      end else if (pick < 70) begin
        queue_frame(n, 1'b1, $urandom_range(0, 1));
      end else if (pick < 76) begin
        line_q.push_back(FLAG_BYTE);
        line_q.push_back(exp_addr);
        line_q.push_back(CTRL_DISC);
      end else if (pick < 81) begin
        line_q.push_back(FLAG_BYTE);
        line_q.push_back(exp_addr);
        line_q.push_back(CTRL_I0);
        line_q.push_back(exp_addr);
        line_q.push_back(FLAG_BYTE);
      end else if (pick < 90) begin
        line_q.push_back(FLAG_BYTE);
        line_q.push_back($urandom_range(0, 1) ? exp_addr : line_byte());
        line_q.push_back($urandom_range(0, 1) ? CTRL_I0 : line_byte());
        line_q.push_back(line_byte());
      end else begin
        repeat ($urandom_range(1, 6)) line_q.push_back(line_byte());
      end
    end
  endtask

  // Wait until every byte is taken and every result seen, then let the pipe settle
  task automatic wait_idle();
    do @(negedge clk_i);
    while (line_q.size() != 0 || s_tvalid || deframed_q.size() != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------- sequencer

  initial begin
    logic [7:0] addr_plan [N_PHASES];
    int         idle_plan [N_PHASES];
    addr_plan = '{ADDR_RESET, 8'h00, 8'hFF, 8'h7E, 8'h7D, 8'($urandom_range(0, 255))};
    idle_plan = '{25, 0, 30, 10, 40, 0};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int p = 0; p < N_PHASES; p++) begin
      if (p > 0) begin
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= addr_plan[p];
        exp_addr  = addr_plan[p];
        @(posedge clk_i);
        cfg_we <= 1'b0;
      end
      @(negedge clk_i);
      idle_pct = idle_plan[p];
      if (p == 0) begin
        foreach (DIRECTED[i]) line_q.push_back(DIRECTED[i]);
      end
      if (p == 2) begin
        // fills the payload to its limit, then overruns it by one byte
        queue_frame(MAX_PAYLOAD + 1, 1'b0, 1'b1);
      end
      queue_random_traffic(line_q.size() + PHASE_BYTES);
    end
    wait_idle();
    if (err_cnt == 0 && deframed_q.size() == 0) begin
      $display("info_frame_deframer test passed");
    end else begin
      $display("info_frame_deframer test failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------- driver

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_tvalid && s_tready) begin
        deframe_byte(s_tdata);
        bytes_in <= bytes_in + 1;
      end
      // move on unless the current beat is still waiting
      if (!(s_tvalid && !s_tready)) begin
        if (src_gap != 0) begin
          src_gap--;
          s_tvalid <= 1'b0;
        end else if (line_q.size() != 0) begin
          s_tvalid <= 1'b1;
          s_tdata  <= line_q.pop_front();
          if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
            src_gap = $urandom_range(1, 13);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- long back-pressure

  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && bytes_in >= HOLD_AFTER) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- monitor

  task automatic log_failure(input string what, input result_t want);
    err_cnt++;
    if (err_cnt <= 10)
      $display("%0t %s: exp kind %0d data %h reply %h len %0d last %b",
               $realtime, what, want.kind, want.data, want.reply, want.flen, want.last,
               " | got kind %0d data %h reply %h len %0d last %b pad %h",
               m_tuser, m_tdata[7:0], m_tdata[15:8], m_tdata[26:16], m_tlast, m_tdata[31:27]);
  endtask

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni) begin
      if (m_tvalid && m_tready) begin
        if (deframed_q.size() == 0) begin
          log_failure("beat with nothing expected", '0);
        end else begin
          want = deframed_q.pop_front();
          if (m_tuser !== want.kind || m_tdata[7:0] !== want.data ||
              m_tdata[15:8] !== want.reply || m_tdata[26:16] !== want.flen ||
              m_tdata[31:27] !== 5'd0 || m_tlast !== want.last)
            log_failure("result mismatch", want);
        end
      end
      if (sink_gap != 0) begin
        sink_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= (hold_left == 0);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
          sink_gap = $urandom_range(1, 13);
      end
    end
  end

  // ---------------------------------------------------------------- watchdog

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("info_frame_deframer test failed");
      $finish;
    end
  end

endmodule
